@@ rtl/alpha_blended_line_rasterizer_assert.svh @@
// assertion macros for the alpha blended line rasterizer
// used by the rtl files that check their own logic; no other dependency
`ifndef ALPHA_BLENDED_LINE_RASTERIZER_ASSERT_SVH
`define ALPHA_BLENDED_LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ABLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ABLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ABLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ABLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/ablr_pkg.sv @@
// shared constants for the alpha blended line rasterizer
// used by the channel interfaces and the top level; no dependencies
package ablr_pkg;

	localparam int COORD_BITS_DEF = 12;

	localparam int CLIP_W  = 12;
	localparam int BOUND_W = 13;
	localparam int CHAN_W  = 8;
	localparam int ALPHA_W = 9;
	localparam int PIXEL_W = 32;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// register indexes, byte address is 4 * index
	localparam logic [2:0] REG_CLIP_MIN_X   = 3'd0;
	localparam logic [2:0] REG_CLIP_MIN_Y   = 3'd1;
	localparam logic [2:0] REG_CLIP_MAX_X   = 3'd2;
	localparam logic [2:0] REG_CLIP_MAX_Y   = 3'd3;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic [BOUND_W-1:0] CLIP_MAX_X_RST   = 13'd1280;
	localparam logic [BOUND_W-1:0] CLIP_MAX_Y_RST   = 13'd720;
	localparam logic [BOUND_W-1:0] FRAME_HEIGHT_RST = 13'd720;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
	localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;
	localparam logic [CHAN_W-1:0]  ALPHA_BYTE = 8'hFF;

endpackage

@@ rtl/ablr_line_if.sv @@
// input channel of the rasterizer: line loads and pixel steps
// depends on ablr_pkg for field widths
interface ablr_line_if #(
	parameter int COORD_BITS = ablr_pkg::COORD_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic signed [COORD_BITS-1:0]    x_start;
	logic signed [COORD_BITS-1:0]    y_start;
	logic signed [COORD_BITS-1:0]    x_end;
	logic signed [COORD_BITS-1:0]    y_end;
	logic [ablr_pkg::CHAN_W-1:0]     red;
	logic [ablr_pkg::CHAN_W-1:0]     green;
	logic [ablr_pkg::CHAN_W-1:0]     blue;
	logic [ablr_pkg::ALPHA_W-1:0]    alpha;
	logic [ablr_pkg::PIXEL_W-1:0]    dest_pixel;

	modport source (
		output valid, kind, x_start, y_start, x_end, y_end, red, green, blue, alpha,
			dest_pixel,
		input ready
	);
	modport sink (
		input valid, kind, x_start, y_start, x_end, y_end, red, green, blue, alpha,
			dest_pixel,
		output ready
	);
endinterface

@@ rtl/ablr_pixel_if.sv @@
// output channel of the rasterizer: blended pixel and next fetch point
// depends on ablr_pkg for field widths
interface ablr_pixel_if #(
	parameter int COORD_BITS = ablr_pkg::COORD_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [COORD_BITS-1:0]    write_x;
	logic signed [COORD_BITS-1:0]    write_y;
	logic                            write_enable;
	logic [ablr_pkg::PIXEL_W-1:0]    blended_pixel;
	logic signed [COORD_BITS-1:0]    next_x;
	logic signed [COORD_BITS-1:0]    next_y;
	logic                            next_inside;
	logic                            line_done;

	modport source (
		output valid, write_x, write_y, write_enable, blended_pixel, next_x, next_y,
			next_inside, line_done,
		input ready
	);
	modport sink (
		input valid, write_x, write_y, write_enable, blended_pixel, next_x, next_y,
			next_inside, line_done,
		output ready
	);
endinterface

@@ rtl/alpha_blended_line_rasterizer.sv @@
// Alpha blended Bresenham line rasterizer. A load transaction latches the endpoints, the
// color and a Q1.8 opacity (values above 256 count as 256) and answers with the start point
// and its clip test. Each step transaction carries the framebuffer word at the point reported
// last; the block blends it when that point is inside the clip window and below the frame
// height, then advances one pixel unless that point is the endpoint, and reports the next
// point to fetch. Every transaction gives exactly one result. The block takes one transaction
// per clock while the result is not stalled; the transaction is held in the input register
// and then captured in the result register, and a stalled result holds both registers. The
// rate is set by the Bresenham state, read and updated once per transaction as it moves from
// the input register into the result register. Clip and frame height registers sit on an
// APB port at byte addresses 0, 4, 8, 12, 16 and are read at each step.
// depends on ablr_pkg, ablr_line_if, ablr_pixel_if and the assertion macro header
`include "alpha_blended_line_rasterizer_assert.svh"

module alpha_blended_line_rasterizer #(
	parameter int COORD_BITS = ablr_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ablr_pkg::PADDR_W-1:0]    paddr,
	input  logic [ablr_pkg::PDATA_W-1:0]    pwdata,
	output logic [ablr_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	ablr_line_if.sink                       line_in,
	ablr_pixel_if.source                    pixel_out
);

	localparam int CW    = COORD_BITS;
	localparam int CMP_W = ((CW > ablr_pkg::BOUND_W) ? CW : ablr_pkg::BOUND_W) + 1;

	// ---------------- configuration registers ----------------
	logic [ablr_pkg::CLIP_W-1:0]  clip_min_x_q, clip_min_y_q;
	logic [ablr_pkg::BOUND_W-1:0] clip_max_x_q, clip_max_y_q, frame_height_q;
	logic                         cfg_wr;
	logic [2:0]                   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_min_x_q   <= '0;
			clip_min_y_q   <= '0;
			clip_max_x_q   <= ablr_pkg::CLIP_MAX_X_RST;
			clip_max_y_q   <= ablr_pkg::CLIP_MAX_Y_RST;
			frame_height_q <= ablr_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				ablr_pkg::REG_CLIP_MIN_X:   clip_min_x_q   <= pwdata[ablr_pkg::CLIP_W-1:0];
				ablr_pkg::REG_CLIP_MIN_Y:   clip_min_y_q   <= pwdata[ablr_pkg::CLIP_W-1:0];
				ablr_pkg::REG_CLIP_MAX_X:   clip_max_x_q   <= pwdata[ablr_pkg::BOUND_W-1:0];
				ablr_pkg::REG_CLIP_MAX_Y:   clip_max_y_q   <= pwdata[ablr_pkg::BOUND_W-1:0];
				ablr_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[ablr_pkg::BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			ablr_pkg::REG_CLIP_MIN_X:
				prdata = {{(ablr_pkg::PDATA_W-ablr_pkg::CLIP_W){1'b0}}, clip_min_x_q};
			ablr_pkg::REG_CLIP_MIN_Y:
				prdata = {{(ablr_pkg::PDATA_W-ablr_pkg::CLIP_W){1'b0}}, clip_min_y_q};
			ablr_pkg::REG_CLIP_MAX_X:
				prdata = {{(ablr_pkg::PDATA_W-ablr_pkg::BOUND_W){1'b0}}, clip_max_x_q};
			ablr_pkg::REG_CLIP_MAX_Y:
				prdata = {{(ablr_pkg::PDATA_W-ablr_pkg::BOUND_W){1'b0}}, clip_max_y_q};
			ablr_pkg::REG_FRAME_HEIGHT:
				prdata = {{(ablr_pkg::PDATA_W-ablr_pkg::BOUND_W){1'b0}}, frame_height_q};
			default: prdata = '0;
		endcase
	end

	// ---------------- helpers ----------------
	function automatic logic inside_clip(
		input logic [CW-1:0]                x,
		input logic [CW-1:0]                y,
		input logic [ablr_pkg::CLIP_W-1:0]  min_x,
		input logic [ablr_pkg::CLIP_W-1:0]  min_y,
		input logic [ablr_pkg::BOUND_W-1:0] max_x,
		input logic [ablr_pkg::BOUND_W-1:0] max_y,
		input logic [ablr_pkg::BOUND_W-1:0] fh
	);
		logic signed [CMP_W-1:0] xs, ys;
		xs = $signed({{(CMP_W-CW){x[CW-1]}}, x});
		ys = $signed({{(CMP_W-CW){y[CW-1]}}, y});
		return (xs >= $signed({{(CMP_W-ablr_pkg::CLIP_W){1'b0}}, min_x})) &&
			(xs < $signed({{(CMP_W-ablr_pkg::BOUND_W){1'b0}}, max_x})) &&
			(ys >= $signed({{(CMP_W-ablr_pkg::CLIP_W){1'b0}}, min_y})) &&
			(ys < $signed({{(CMP_W-ablr_pkg::BOUND_W){1'b0}}, max_y})) &&
			(ys < $signed({{(CMP_W-ablr_pkg::BOUND_W){1'b0}}, fh}));
	endfunction

	// c*a>>8, never above 255 since a <= 256
	function automatic logic [7:0] src_chan(input logic [7:0] c, input logic [8:0] a);
		logic [16:0] prod;
		prod = {9'd0, c} * {8'd0, a};
		return prod[15:8];
	endfunction

	function automatic logic [7:0] blend_chan(
		input logic [7:0] s,
		input logic [7:0] d,
		input logic [8:0] inv
	);
		logic [16:0] prod;
		logic [8:0]  sum;
		prod = {9'd0, d} * {8'd0, inv};
		sum  = {1'b0, s} + prod[16:8];
		return (sum > {1'b0, ablr_pkg::CHAN_MAX}) ? ablr_pkg::CHAN_MAX : sum[7:0];
	endfunction

	// ---------------- input register ----------------
	logic                         valid_s1;
	logic                         kind_s1;
	logic [CW-1:0]                x_start_s1, y_start_s1, x_end_s1, y_end_s1;
	logic [7:0]                   red_s1, green_s1, blue_s1;
	logic [ablr_pkg::ALPHA_W-1:0] alpha_s1;
	logic [ablr_pkg::PIXEL_W-1:0] dest_s1;
	logic                         out_valid_q;
	logic                         adv;
	logic                         fire;

	assign adv           = !out_valid_q || pixel_out.ready;
	assign fire          = valid_s1 && adv;
	assign line_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_in.ready) begin
			valid_s1 <= line_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_in.valid && line_in.ready) begin
			kind_s1    <= line_in.kind;
			x_start_s1 <= line_in.x_start;
			y_start_s1 <= line_in.y_start;
			x_end_s1   <= line_in.x_end;
			y_end_s1   <= line_in.y_end;
			red_s1     <= line_in.red;
			green_s1   <= line_in.green;
			blue_s1    <= line_in.blue;
			alpha_s1   <= line_in.alpha;
			dest_s1    <= line_in.dest_pixel;
		end
	end

	// ---------------- line state ----------------
	logic [CW-1:0]                cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [CW:0]                  delta_x_q, delta_y_q;
	logic                         step_neg_x_q, step_neg_y_q;
	logic [CW+2:0]                error_term_q;
	logic [23:0]                  src_rgb_q;
	logic [ablr_pkg::ALPHA_W-1:0] inv_alpha_q;
	logic                         line_active_q;

	logic [CW-1:0]                cur_x_d, cur_y_d, end_x_d, end_y_d;
	logic [CW:0]                  delta_x_d, delta_y_d;
	logic                         step_neg_x_d, step_neg_y_d;
	logic [CW+2:0]                error_term_d;
	logic [23:0]                  src_rgb_d;
	logic [ablr_pkg::ALPHA_W-1:0] inv_alpha_d;
	logic                         line_active_d;

	// result of the item in the input register
	logic [CW-1:0]                r_write_x, r_write_y, r_next_x, r_next_y;
	logic                         r_write_enable, r_next_inside, r_line_done;
	logic [ablr_pkg::PIXEL_W-1:0] r_pixel;

	// load datapath
	logic [CW:0]                  dxs, dys, dx_abs, dy_abs;
	logic [ablr_pkg::ALPHA_W-1:0] a_sat;

	// step datapath
	logic signed [CW+3:0]         e2, dx_ext, dy_neg, err_sum;
	logic                         mv_x, mv_y, at_end, cur_in;

	always_comb begin
		dxs    = {x_end_s1[CW-1], x_end_s1} - {x_start_s1[CW-1], x_start_s1};
		dys    = {y_end_s1[CW-1], y_end_s1} - {y_start_s1[CW-1], y_start_s1};
		dx_abs = dxs[CW] ? (~dxs + 1'b1) : dxs;
		dy_abs = dys[CW] ? (~dys + 1'b1) : dys;
		a_sat  = (alpha_s1 > ablr_pkg::ALPHA_ONE) ? ablr_pkg::ALPHA_ONE : alpha_s1;

		e2      = $signed({error_term_q, 1'b0});
		dx_ext  = $signed({3'b000, delta_x_q});
		dy_neg  = -$signed({3'b000, delta_y_q});
		mv_x    = e2 > dy_neg;
		mv_y    = e2 < dx_ext;
		err_sum = $signed({error_term_q[CW+2], error_term_q}) + (mv_x ? dy_neg : '0)
			+ (mv_y ? dx_ext : '0);
		at_end  = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
		cur_in  = inside_clip(cur_x_q, cur_y_q, clip_min_x_q, clip_min_y_q,
			clip_max_x_q, clip_max_y_q, frame_height_q);

		cur_x_d       = cur_x_q;
		cur_y_d       = cur_y_q;
		end_x_d       = end_x_q;
		end_y_d       = end_y_q;
		delta_x_d     = delta_x_q;
		delta_y_d     = delta_y_q;
		step_neg_x_d  = step_neg_x_q;
		step_neg_y_d  = step_neg_y_q;
		error_term_d  = error_term_q;
		src_rgb_d     = src_rgb_q;
		inv_alpha_d   = inv_alpha_q;
		line_active_d = line_active_q;

		r_write_x      = '0;
		r_write_y      = '0;
		r_write_enable = 1'b0;
		r_pixel        = '0;
		r_line_done    = 1'b0;
		r_next_inside  = 1'b0;

		unique case (kind_s1)
			ablr_pkg::KIND_LOAD: begin
				cur_x_d       = x_start_s1;
				cur_y_d       = y_start_s1;
				end_x_d       = x_end_s1;
				end_y_d       = y_end_s1;
				delta_x_d     = dx_abs;
				delta_y_d     = dy_abs;
				step_neg_x_d  = dxs[CW] || (dxs == '0);
				step_neg_y_d  = dys[CW] || (dys == '0);
				error_term_d  = {2'b00, dx_abs} - {2'b00, dy_abs};
				src_rgb_d     = {src_chan(blue_s1, a_sat), src_chan(green_s1, a_sat),
					src_chan(red_s1, a_sat)};
				inv_alpha_d   = ablr_pkg::ALPHA_ONE - a_sat;
				line_active_d = 1'b1;
			end
			ablr_pkg::KIND_STEP: begin
				if (!line_active_q) begin
					r_line_done = 1'b1;
				end else begin
					r_write_x      = cur_x_q;
					r_write_y      = cur_y_q;
					r_write_enable = cur_in;
					if (cur_in) begin
						r_pixel = {ablr_pkg::ALPHA_BYTE,
							blend_chan(src_rgb_q[23:16], dest_s1[23:16], inv_alpha_q),
							blend_chan(src_rgb_q[15:8], dest_s1[15:8], inv_alpha_q),
							blend_chan(src_rgb_q[7:0], dest_s1[7:0], inv_alpha_q)};
					end
					if (at_end) begin
						line_active_d = 1'b0;
						r_line_done   = 1'b1;
					end else begin
						error_term_d = err_sum[CW+2:0];
						// +1 or -1 in two's complement
						if (mv_x) begin
							cur_x_d = cur_x_q + {{(CW-1){step_neg_x_q}}, 1'b1};
						end
						if (mv_y) begin
							cur_y_d = cur_y_q + {{(CW-1){step_neg_y_q}}, 1'b1};
						end
					end
				end
			end
			default: ;
		endcase

		r_next_x = cur_x_d;
		r_next_y = cur_y_d;
		// no fetch point once the line is finished or absent
		if (line_active_d) begin
			r_next_inside = inside_clip(cur_x_d, cur_y_d, clip_min_x_q, clip_min_y_q,
				clip_max_x_q, clip_max_y_q, frame_height_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			end_x_q       <= '0;
			end_y_q       <= '0;
			delta_x_q     <= '0;
			delta_y_q     <= '0;
			step_neg_x_q  <= 1'b0;
			step_neg_y_q  <= 1'b0;
			error_term_q  <= '0;
			src_rgb_q     <= '0;
			inv_alpha_q   <= '0;
			line_active_q <= 1'b0;
		end else if (fire) begin
			cur_x_q       <= cur_x_d;
			cur_y_q       <= cur_y_d;
			end_x_q       <= end_x_d;
			end_y_q       <= end_y_d;
			delta_x_q     <= delta_x_d;
			delta_y_q     <= delta_y_d;
			step_neg_x_q  <= step_neg_x_d;
			step_neg_y_q  <= step_neg_y_d;
			error_term_q  <= error_term_d;
			src_rgb_q     <= src_rgb_d;
			inv_alpha_q   <= inv_alpha_d;
			line_active_q <= line_active_d;
		end
	end

	// ---------------- result register ----------------
	logic [CW-1:0]                write_x_q, write_y_q, next_x_q, next_y_q;
	logic                         write_enable_q, next_inside_q, line_done_q;
	logic [ablr_pkg::PIXEL_W-1:0] blended_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			write_x_q       <= r_write_x;
			write_y_q       <= r_write_y;
			write_enable_q  <= r_write_enable;
			blended_pixel_q <= r_pixel;
			next_x_q        <= r_next_x;
			next_y_q        <= r_next_y;
			next_inside_q   <= r_next_inside;
			line_done_q     <= r_line_done;
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.write_x       = write_x_q;
	assign pixel_out.write_y       = write_y_q;
	assign pixel_out.write_enable  = write_enable_q;
	assign pixel_out.blended_pixel = blended_pixel_q;
	assign pixel_out.next_x        = next_x_q;
	assign pixel_out.next_y        = next_y_q;
	assign pixel_out.next_inside   = next_inside_q;
	assign pixel_out.line_done     = line_done_q;

	// ---------------- checks ----------------
	`ABLR_ASSERT_NXT(a_idle_step, clk, arst_n,
		fire && (kind_s1 == ablr_pkg::KIND_STEP) && !line_active_q,
		line_done_q && !write_enable_q && (next_x_q == $past(cur_x_q)),
		"step without a line must report done and leave the position alone")
	`ABLR_ASSERT_NXT(a_load_arms, clk, arst_n,
		fire && (kind_s1 == ablr_pkg::KIND_LOAD),
		line_active_q && !line_done_q && !write_enable_q,
		"load must start a line and write nothing")
	`ABLR_ASSERT_IMP(a_end_only, clk, arst_n,
		$fell(line_active_q),
		line_done_q && (next_x_q == end_x_q) && (next_y_q == end_y_q),
		"line may only finish at its endpoint")
	`ABLR_ASSERT_IMP(a_fetch_live, clk, arst_n,
		out_valid_q && next_inside_q,
		!line_done_q,
		"a finished line must not ask for another pixel")
	`ABLR_ASSERT_IMP(a_blend_alpha, clk, arst_n,
		out_valid_q && write_enable_q,
		blended_pixel_q[31:24] == ablr_pkg::ALPHA_BYTE,
		"stored pixel must be opaque")

endmodule
